[hw/rtl/dlt_pkg.sv]
// ----------------------------------------------------------------------------
// Delta index decoder package
// Shared widths, mode and status codes, register indexes and record types.
// ----------------------------------------------------------------------------
package dlt_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IDX_W     = 32;
    localparam int unsigned MODE_W    = 4;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned PEND_W    = 24;
    localparam int unsigned CNT_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    // Code formats
    localparam logic [MODE_W-1:0] MODE_INT8     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INT16    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INT32    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BASE254  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_BASE250  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ESC255   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_INT15EXT = 4'd9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODING_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef struct packed {
        logic [MODE_W-1:0] coding_mode;
        logic [IDX_W-1:0]  feature_count;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]  previous_index;
        logic [PEND_W-1:0] pending_bytes;
        logic [CNT_W-1:0]  pending_count;
        logic              discarding;
    } t_rec_state;

    typedef struct packed {
        logic [IDX_W-1:0] feature_index;
        t_status          status;
        logic             last_in_record;
    } t_result;

endpackage

[hw/rtl/dlt_in_if.sv]
// ----------------------------------------------------------------------------
// Code byte channel
// Valid/ready channel carrying one code byte and its record end flag.
// ----------------------------------------------------------------------------
interface dlt_in_if;
    import dlt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic              record_end;

    modport source (output valid, output code_byte, output record_end, input ready);
    modport sink   (input valid, input code_byte, input record_end, output ready);
endinterface

[hw/rtl/dlt_out_if.sv]
// ----------------------------------------------------------------------------
// Feature index channel
// Valid/ready channel carrying one decoded index with its status.
// ----------------------------------------------------------------------------
interface dlt_out_if;
    import dlt_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    feature_index;
    logic [STATUS_W-1:0] status;
    logic                last_in_record;

    modport source (output valid, output feature_index, output status,
                    output last_in_record, input ready);
    modport sink   (input valid, input feature_index, input status,
                    input last_in_record, output ready);
endinterface

[hw/rtl/dlt_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface dlt_cfg_if;
    import dlt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/delta_index_decoder.sv]
// ----------------------------------------------------------------------------
// Delta index decoder
// Decode delta-coded sparse feature indices from a stream of code bytes.
// ----------------------------------------------------------------------------
// A byte is registered in the input stage; the decode, 32-bit add and range
// compare on the running index sit in one stage before the result register.
// Throughput: one byte per cycle unless a result waits unaccepted on o_out.
// Reset (synchronous, active low): coding mode int8, feature count all ones,
// running index, pending code bytes and discard flag cleared, both stages empty.
// ----------------------------------------------------------------------------
module delta_index_decoder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dlt_in_if.sink   i_in,
    dlt_out_if.source o_out,
    dlt_cfg_if.sink  i_cfg
);
    import dlt_pkg::*;

    // Configuration
    t_cfg cfg;
    logic mode_wr;

    // Input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_code_byte;
    logic              r_in_record_end;

    // Record state and result stage
    t_rec_state r_state;
    t_rec_state n_state;
    t_rec_state step_state;
    logic       res_valid;
    t_result    result;
    logic       r_out_valid;
    t_result    r_out;

    logic in_xfer;
    logic advance;

    dlt_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_cfg     (cfg),
        .o_mode_wr (mode_wr)
    );

    dlt_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_code_byte  (r_in_code_byte),
        .i_record_end (r_in_record_end),
        .o_state      (step_state),
        .o_res_valid  (res_valid),
        .o_result     (result)
    );

    // Advance the held byte whenever the result register is free or draining;
    // bytes that only extend a code advance too and leave the result alone.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.feature_index  = r_out.feature_index;
    assign o_out.status         = r_out.status;
    assign o_out.last_in_record = r_out.last_in_record;

    // Take the step's record state on an advance, else hold.
    // A new coding mode drops any partly gathered code.
    always_comb begin
        n_state = advance ? step_state : r_state;
        if (mode_wr) begin
            n_state.pending_bytes = '0;
            n_state.pending_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            r_state <= n_state;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_code_byte  <= i_in.code_byte;
            r_in_record_end <= i_in.record_end;
        end
        if (advance && res_valid) begin
            r_out <= result;
        end
    end
endmodule

[hw/rtl/dlt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Hold coding mode and feature count; flag a coding mode write.
// ----------------------------------------------------------------------------
module dlt_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dlt_cfg_if.sink       i_cfg,
    output dlt_pkg::t_cfg o_cfg,
    output logic          o_mode_wr
);
    import dlt_pkg::*;

    t_cfg r_cfg;
    logic cfg_xfer;

    assign i_cfg.ready = 1'b1;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;
    assign o_mode_wr   = cfg_xfer && (i_cfg.index == CFG_CODING_MODE);
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coding_mode   <= MODE_INT8;
            r_cfg.feature_count <= '1;
        end else if (cfg_xfer) begin
            unique case (i_cfg.index)
                CFG_CODING_MODE:   r_cfg.coding_mode   <= i_cfg.data[MODE_W-1:0];
                CFG_FEATURE_COUNT: r_cfg.feature_count <= i_cfg.data[IDX_W-1:0];
                default: ;
            endcase
        end
    end
endmodule

[hw/rtl/dlt_step.sv]
// ----------------------------------------------------------------------------
// Byte step logic
// Decode one code byte against the record state; give next state and result.
// ----------------------------------------------------------------------------
module dlt_step (
    input  dlt_pkg::t_cfg       i_cfg,
    input  dlt_pkg::t_rec_state i_state,
    input  logic [7:0]          i_code_byte,
    input  logic                i_record_end,
    output dlt_pkg::t_rec_state o_state,
    output logic                o_res_valid,
    output dlt_pkg::t_result    o_result
);
    import dlt_pkg::*;

    logic [BYTE_W-1:0] b0, b1, b2, b3;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] hi;
    logic [2:0]        needed;
    logic [2:0]        have;
    logic [IDX_W-1:0]  delta;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;

    assign cnt = i_state.pending_count;

    // Gather code bytes: stored ones first, then the current byte
    always_comb begin
        b0 = (cnt == 2'd0) ? i_code_byte : i_state.pending_bytes[7:0];
        b1 = (cnt > 2'd1) ? i_state.pending_bytes[15:8]
           : (cnt == 2'd1) ? i_code_byte : '0;
        b2 = (cnt > 2'd2) ? i_state.pending_bytes[23:16]
           : (cnt == 2'd2) ? i_code_byte : '0;
        b3 = (cnt == 2'd3) ? i_code_byte : '0;
    end

    assign base = 8'(9'd257 - {5'b0, i_cfg.coding_mode});
    assign hi   = 8'(b0 - base - 8'd1);

    // Code length and delta by format
    always_comb begin
        needed = 3'd1;
        delta  = {24'b0, b0};
        case (i_cfg.coding_mode) inside
            MODE_INT16: begin
                needed = 3'd2;
                delta  = {16'b0, b1, b0};
            end
            MODE_INT32: begin
                needed = 3'd4;
                delta  = {b3, b2, b1, b0};
            end
            [MODE_BASE254:MODE_BASE250]: begin
                if (b0 > base) begin
                    needed = 3'd2;
                    delta  = 32'({1'b0, base} + 9'd1) + {16'b0, hi, b1};
                end
            end
            MODE_ESC255: begin
                if (b0 == 8'hFF) begin
                    needed = 3'd3;
                    delta  = {16'b0, b2, b1};
                end
            end
            MODE_INT15EXT: begin
                if (b0[7]) begin
                    needed = 3'd2;
                    delta  = {17'b0, b1, b0[6:0]};
                end
            end
            default: ;
        endcase
    end

    assign have = {1'b0, cnt} + 3'd1;
    assign idx  = i_state.previous_index + delta;

    always_comb begin
        o_state                 = i_state;
        o_res_valid             = 1'b0;
        o_result.feature_index  = idx;
        o_result.status         = ST_OK;
        o_result.last_in_record = i_record_end;
        if (i_state.discarding) begin
            if (i_record_end) o_state = '0;
        end else if (have < needed) begin
            if (i_record_end) begin
                o_res_valid            = 1'b1;
                o_result.feature_index = '0;
                o_result.status        = ST_TRUNC;
                o_state                = '0;
            end else begin
                case (cnt)
                    2'd0:    o_state.pending_bytes[7:0]   = i_code_byte;
                    2'd1:    o_state.pending_bytes[15:8]  = i_code_byte;
                    2'd2:    o_state.pending_bytes[23:16] = i_code_byte;
                    default: ;
                endcase
                o_state.pending_count = CNT_W'(have);
            end
        end else begin
            o_res_valid           = 1'b1;
            o_state.pending_bytes = '0;
            o_state.pending_count = '0;
            if (idx >= i_cfg.feature_count) begin
                o_result.status = ST_RANGE;
                if (i_record_end) o_state = '0;
                else o_state.discarding = 1'b1;
            end else begin
                o_state.previous_index = i_record_end ? '0 : idx;
            end
        end
    end
endmodule

[bench/tb_delta_index_decoder.sv]
// ----------------------------------------------------------------------------
// Delta index decoder testbench
// Checks every decoded index, status and record end flag against a local
// decoder model. A short table of hand-made records comes first, then random
// records in every code format under random register settings and stalls.
// ----------------------------------------------------------------------------
module tb_delta_index_decoder;
    import dlt_pkg::*;

    // Spare encodings: a mode with no format of its own and the unused
    // register indexes.
    localparam logic [MODE_W-1:0]    MODE_SPARE     = 4'd15;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = 2'd3;

    // Margin past the input and result registers: a byte in flight with no result
    // must be through before a register changes under it.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_GUARD   = 20000;
    localparam int BYTES_WANTED  = 2000;
    localparam int QUIET_FROM    = 1700;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [CFG_DAT_W-1:0] reg_val;
        logic [BYTE_W-1:0]    code;
        logic                 fin;
        bit                   typed;
        t_result              known;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dlt_in_if  code_ch ();
    dlt_out_if index_ch ();
    dlt_cfg_if reg_ch ();

    delta_index_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (code_ch),
        .o_out   (index_ch),
        .i_cfg   (reg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Decoder model state: registers and the record being decoded.
    logic [MODE_W-1:0] cur_mode;
    logic [IDX_W-1:0]  cur_limit;
    logic [IDX_W-1:0]  run_index;
    logic [PEND_W-1:0] held_bytes;
    logic [CNT_W-1:0]  held_count;
    logic              skip_record;

    t_result indices_due[$];

    bit calm;
    bit quiet;
    int mismatches;
    int bytes_fed;
    int indices_seen;
    int range_hits;
    int trunc_hits;
    int settings;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic int code_len(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] first);
        logic [8:0] base;
        base = 9'd254 - 9'(m - MODE_BASE254);
        case (m)
            MODE_INT16:    return 2;
            MODE_INT32:    return 4;
            MODE_ESC255:   return (first < 8'd255) ? 1 : 3;
            MODE_INT15EXT: return (first < 8'd128) ? 1 : 2;
            default: begin
                if (m >= MODE_BASE254 && m <= MODE_BASE250)
                    return (9'(first) <= base) ? 1 : 2;
                return 1;
            end
        endcase
    endfunction

    // word holds the code bytes, first byte in the low eight bits
    function automatic logic [IDX_W-1:0] code_delta(logic [MODE_W-1:0] m,
                                                     logic [31:0] word);
        logic [31:0] base;
        logic [31:0] b0;
        logic [31:0] b1;
        base = 32'd254 - 32'(m - MODE_BASE254);
        b0   = 32'(word[7:0]);
        b1   = 32'(word[15:8]);
        case (m)
            MODE_INT16:    return {16'd0, word[15:0]};
            MODE_INT32:    return word;
            MODE_ESC255:   return (b0 < 32'd255) ? b0 : {16'd0, word[23:8]};
            MODE_INT15EXT: return (b0 < 32'd128) ? b0 : ((b1 << 7) | (b0 & 32'd127));
            default: begin
                if (m >= MODE_BASE254 && m <= MODE_BASE250) begin
                    if (b0 <= base)
                        return b0;
                    return base + 32'd1 + (b0 - (base + 32'd1)) * 32'd256 + b1;
                end
                return b0;
            end
        endcase
    endfunction

    function automatic void clear_record_state();
        run_index   = '0;
        held_bytes  = '0;
        held_count  = '0;
        skip_record = 1'b0;
    endfunction

    // Advance the model by one code byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] code, input logic fin,
                                       output t_result res);
        logic [BYTE_W-1:0] first;
        int                need;
        logic [31:0]       word;
        logic [IDX_W-1:0]  idx;
        res = '0;
        if (skip_record) begin
            if (fin)
                clear_record_state();
            return 1'b0;
        end
        first = (held_count != 0) ? held_bytes[7:0] : code;
        need  = code_len(cur_mode, first);
        if (int'(held_count) + 1 < need) begin
            if (fin) begin
                res.feature_index  = '0;
                res.status         = ST_TRUNC;
                res.last_in_record = 1'b1;
                clear_record_state();
                return 1'b1;
            end
            held_bytes = held_bytes | (PEND_W'(code) << (8 * held_count));
            held_count = held_count + 1'b1;
            return 1'b0;
        end
        word       = 32'(held_bytes) | (32'(code) << (8 * held_count));
        held_bytes = '0;
        held_count = '0;
        idx = run_index + code_delta(cur_mode, word);
        res.feature_index  = idx;
        res.last_in_record = fin;
        if (idx >= cur_limit) begin
            res.status = ST_RANGE;
            if (fin)
                clear_record_state();
            else
                skip_record = 1'b1;
        end else begin
            res.status = ST_OK;
            run_index  = fin ? '0 : idx;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_stim_row row_byte(logic [BYTE_W-1:0] code, logic fin);
        t_stim_row r;
        r = '{default: '0};
        r.code = code;
        r.fin  = fin;
        return r;
    endfunction

    function automatic t_stim_row row_known(logic [BYTE_W-1:0] code, logic fin,
                                            logic [IDX_W-1:0] idx, t_status st,
                                            logic last);
        t_stim_row r;
        r = row_byte(code, fin);
        r.typed                = 1'b1;
        r.known.feature_index  = idx;
        r.known.status         = st;
        r.known.last_in_record = last;
        return r;
    endfunction

    function automatic t_stim_row row_reg(logic [CFG_IDX_W-1:0] sel,
                                          logic [CFG_DAT_W-1:0] val);
        t_stim_row r;
        r = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    // Mix of full-range, small and near-top bytes so that every escape
    // and every plain branch of each format is reached.
    function automatic logic [BYTE_W-1:0] rand_code_byte();
        case ($urandom_range(0, 3))
            0:       return BYTE_W'($urandom_range(0, 255));
            1:       return BYTE_W'($urandom_range(0, 15));
            2:       return BYTE_W'($urandom_range(240, 255));
            default: return '0;
        endcase
    endfunction

    // Present one byte, hold it until the transfer, then queue what the
    // model says it gives. A typed row overrides the model's result.
    task automatic feed(logic [BYTE_W-1:0] code, logic fin, bit typed, t_result known);
        t_result got;
        bit      has;
        if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            code_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        code_ch.valid      <= 1'b1;
        code_ch.code_byte  <= code;
        code_ch.record_end <= fin;
        do @(posedge i_clk); while (!code_ch.ready);
        bytes_fed++;
        has = decode_byte(code, fin, got);
        if (typed)
            indices_due.push_back(known);
        else if (has)
            indices_due.push_back(got);
    endtask

    // Leave valid high on return; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DAT_W-1:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= sel;
        reg_ch.data  <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
        if (sel == CFG_CODING_MODE) begin
            cur_mode   = val[MODE_W-1:0];
            held_bytes = '0;
            held_count = '0;
        end else if (sel == CFG_FEATURE_COUNT) begin
            cur_limit = val;
        end
    endtask

    // Stop feeding, wait for every queued result, then let the pipe empty.
    task automatic drain_decoder();
        int guard;
        guard = 0;
        code_ch.valid <= 1'b0;
        while (indices_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stall bursts, none while calm or once the run goes quiet
    // ------------------------------------------------------------------
    initial begin
        int hold;
        hold = 0;
        index_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet || calm) begin
                index_ch.ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 5) == 0) begin
                index_ch.ready <= 1'b0;
                hold = $urandom_range(1, 13) - 1;
            end else begin
                index_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && index_ch.valid && index_ch.ready) begin
            if (indices_due.size() == 0) begin
                $error("result with none expected: feature_index %0h status %0d last %0b",
                       index_ch.feature_index, index_ch.status, index_ch.last_in_record);
                mismatches++;
            end else begin
                want = indices_due.pop_front();
                indices_seen++;
                if (want.status == ST_RANGE)
                    range_hits++;
                if (want.status == ST_TRUNC)
                    trunc_hits++;
                if (index_ch.feature_index !== want.feature_index) begin
                    $error("feature_index: expected %0h, got %0h",
                           want.feature_index, index_ch.feature_index);
                    mismatches++;
                end
                if (index_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, index_ch.status);
                    mismatches++;
                end
                if (index_ch.last_in_record !== want.last_in_record) begin
                    $error("last_in_record: expected %0b, got %0b",
                           want.last_in_record, index_ch.last_in_record);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_stim_row         plan[$];
        logic [BYTE_W-1:0] rec_bytes[$];
        logic [BYTE_W-1:0] first;
        logic [MODE_W-1:0] mode_pick;
        logic [IDX_W-1:0]  limit_pick;
        logic [31:0]       mode_word;
        int                last_len;
        int                ncodes;
        int                kind;
        int                n_rec;

        // Hold every input at a known value from time zero.
        i_rst_n            = 1'b0;
        code_ch.valid      = 1'b0;
        code_ch.code_byte  = '0;
        code_ch.record_end = 1'b0;
        reg_ch.valid       = 1'b0;
        reg_ch.index       = CFG_CODING_MODE;
        reg_ch.data        = '0;
        calm  = 1'b0;
        quiet = 1'b0;
        mismatches   = 0;
        bytes_fed    = 0;
        indices_seen = 0;
        range_hits   = 0;
        trunc_hits   = 0;
        settings     = 0;
        cur_mode  = MODE_INT8;
        cur_limit = '1;
        clear_record_state();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Rows with a typed result can be checked by eye:
        // reset values, field extremes and both error codes.
        // Plain int8 after reset, smallest and largest delta.
        plan.push_back(row_known(8'h00, 1'b0, 32'd0,   ST_OK, 1'b0));
        plan.push_back(row_known(8'hFF, 1'b1, 32'd255, ST_OK, 1'b1));
        // A feature count of zero rejects everything; the rest of the
        // record is dropped and its end clears the discard.
        plan.push_back(row_reg(CFG_FEATURE_COUNT, 32'd0));
        plan.push_back(row_known(8'h00, 1'b0, 32'd0, ST_RANGE, 1'b0));
        plan.push_back(row_byte(8'h55, 1'b0));
        plan.push_back(row_byte(8'hAA, 1'b1));
        plan.push_back(row_reg(CFG_FEATURE_COUNT, 32'hFFFF_FFFF));
        // int16 little endian, then a code cut short by the record end.
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_INT16)));
        plan.push_back(row_byte(8'h34, 1'b0));
        plan.push_back(row_known(8'h12, 1'b0, 32'h1234, ST_OK, 1'b0));
        plan.push_back(row_known(8'h01, 1'b1, 32'd0, ST_TRUNC, 1'b1));
        // int32 all ones: equal to the largest feature count, so out of range.
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_INT32)));
        plan.push_back(row_byte(8'hFF, 1'b0));
        plan.push_back(row_byte(8'hFF, 1'b0));
        plan.push_back(row_byte(8'hFF, 1'b0));
        plan.push_back(row_known(8'hFF, 1'b1, 32'hFFFF_FFFF, ST_RANGE, 1'b1));
        // Base 254: plain top value, then a two-byte escape.
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_BASE254)));
        plan.push_back(row_byte(8'hFE, 1'b0));
        plan.push_back(row_byte(8'hFF, 1'b0));
        plan.push_back(row_byte(8'h07, 1'b1));
        // Base 250 with the largest escape.
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_BASE250)));
        plan.push_back(row_byte(8'hFF, 1'b0));
        plan.push_back(row_byte(8'hFF, 1'b1));
        // 0xFF escape followed by a 16-bit delta.
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_ESC255)));
        plan.push_back(row_byte(8'hFF, 1'b0));
        plan.push_back(row_byte(8'h34, 1'b0));
        plan.push_back(row_byte(8'h12, 1'b1));
        // 7/15-bit extension.
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_INT15EXT)));
        plan.push_back(row_byte(8'h85, 1'b0));
        plan.push_back(row_byte(8'h03, 1'b1));
        // An undefined mode decodes as int8.
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_SPARE)));
        plan.push_back(row_byte(8'h80, 1'b1));
        // A mode write drops a half-gathered code.
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_INT16)));
        plan.push_back(row_byte(8'h11, 1'b0));
        plan.push_back(row_reg(CFG_CODING_MODE, 32'(MODE_INT8)));
        plan.push_back(row_byte(8'h22, 1'b1));

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                drain_decoder();
                write_reg(plan[i].reg_sel, plan[i].reg_val);
                reg_ch.valid <= 1'b0;
                settings++;
            end else begin
                feed(plan[i].code, plan[i].fin, plan[i].typed, plan[i].known);
            end
        end

        // Random part: a fresh register setting per pass, then a batch of
        // records, mostly well formed with random content.
        while (bytes_fed < BYTES_WANTED) begin
            drain_decoder();
            quiet = (bytes_fed >= QUIET_FROM);
            calm  = ($urandom_range(0, 3) == 0);

            mode_pick = MODE_W'($urandom_range(0, 10));
            if (mode_pick == 4'd10)
                mode_pick = MODE_W'($urandom_range(10, 15));
            // Junk above the mode field is ignored; send some now and then.
            mode_word = 32'(mode_pick);
            if ($urandom_range(0, 3) == 0)
                mode_word = ($urandom() & 32'hFFFF_FFF0) | mode_word;
            case ($urandom_range(0, 4))
                0:       limit_pick = '1;
                1:       limit_pick = 32'd1;
                2:       limit_pick = $urandom();
                3:       limit_pick = $urandom_range(50, 5000);
                default: limit_pick = $urandom_range(5000, 2000000);
            endcase

            if ($urandom_range(0, 1)) begin
                write_reg(CFG_CODING_MODE, mode_word);
                write_reg(CFG_FEATURE_COUNT, limit_pick);
            end else begin
                write_reg(CFG_FEATURE_COUNT, limit_pick);
                write_reg(CFG_CODING_MODE, mode_word);
            end
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom());
            reg_ch.valid <= 1'b0;
            settings++;

            n_rec = $urandom_range(3, 12);
            repeat (n_rec) begin
                rec_bytes.delete();
                last_len = 1;
                ncodes   = $urandom_range(1, 6);
                for (int c = 0; c < ncodes; c++) begin
                    first    = rand_code_byte();
                    last_len = code_len(cur_mode, first);
                    rec_bytes.push_back(first);
                    for (int k = 1; k < last_len; k++)
                        rec_bytes.push_back(rand_code_byte());
                end
                kind = $urandom_range(0, 9);
                // Cut the last code short so the record end lands inside it.
                if (kind == 8 && last_len > 1)
                    repeat ($urandom_range(1, last_len - 1)) void'(rec_bytes.pop_back());
                // Noise: random bytes with random record ends.
                if (kind == 9) begin
                    rec_bytes.delete();
                    repeat ($urandom_range(1, 8))
                        rec_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
                end
                foreach (rec_bytes[i])
                    feed(rec_bytes[i],
                         (kind == 9) ? 1'($urandom_range(0, 1)) : (i == rec_bytes.size() - 1),
                         1'b0, '0);
            end
        end

        drain_decoder();
        if (indices_due.size() != 0) begin
            $error("%0d expected results never arrived", indices_due.size());
            mismatches++;
        end

        $display("Fed %0d code bytes across %0d register settings and all ten formats.",
                 bytes_fed, settings);
        $display("Checked %0d results: %0d out of range, %0d truncated.",
                 indices_seen, range_hits, trunc_hits);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
